>>> design/tal_pkg.sv
// tag attribute lexer package: lexer state enum, role and error codes,
// character class and result structs used by tal_class, tal_fsm and the core
// no dependencies
`default_nettype none

package tal_pkg;

	// lexer states
	typedef enum logic [2:0] {
		LS_BEGIN     = 3'd0,
		LS_TAG_NAME  = 3'd1,
		LS_ATTR_GAP  = 3'd2,
		LS_ATTR_NAME = 3'd3,
		LS_AFTER_NAM = 3'd4,
		LS_AFTER_EQ  = 3'd5,
		LS_QUOTED    = 3'd6,
		LS_UNQUOTED  = 3'd7
	} lex_state_t;

	// character roles
	localparam logic [1:0] ROLE_SKIP  = 2'd0;
	localparam logic [1:0] ROLE_TAG   = 2'd1;
	localparam logic [1:0] ROLE_ANAME = 2'd2;
	localparam logic [1:0] ROLE_VALUE = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_TAG     = 3'd1;
	localparam logic [2:0] ERR_ATTR    = 3'd2;
	localparam logic [2:0] ERR_VALUE   = 3'd3;
	localparam logic [2:0] ERR_UNNAMED = 3'd4;

	// item kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// punctuation that matters to the lexer
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// ascii class flags of one byte
	typedef struct packed {
		logic alpha;
		logic digit;
		logic ws;
		logic under;
		logic colon;
		logic eq;
		logic dot;
		logic dash;
		logic quote;
	} char_class_t;

	// one result transaction
	typedef struct packed {
		logic [1:0] role;
		logic [7:0] byte_out;
		logic       attr_commit;
		logic [2:0] error_code;
		logic       tag_done;
		logic       empty_tag_out;
	} token_t;

endpackage

`default_nettype wire

>>> design/tal_if.sv
// handshake channels of the tag attribute lexer: character input and token output
// no dependencies
`default_nettype none

interface tal_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_in;
	logic       is_empty_tag;

	modport source (output valid, output kind, output byte_in, output is_empty_tag,
		input ready);
	modport sink (input valid, input kind, input byte_in, input is_empty_tag,
		output ready);
endinterface

interface tal_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] role;
	logic [7:0] byte_out;
	logic       attr_commit;
	logic [2:0] error_code;
	logic       tag_done;
	logic       empty_tag_out;

	modport source (output valid, output role, output byte_out, output attr_commit,
		output error_code, output tag_done, output empty_tag_out, input ready);
	modport sink (input valid, input role, input byte_out, input attr_commit,
		input error_code, input tag_done, input empty_tag_out, output ready);
endinterface

`default_nettype wire

>>> design/tal_class.sv
// ascii character class decoder for the tag attribute lexer
// depends on tal_pkg
`default_nettype none

module tal_class
	import tal_pkg::*;
(
	input  wire logic [7:0]  ch,
	output char_class_t      cls
);

	// plain range and equality compares, bytes above 127 match nothing
	always_comb begin
		cls.alpha = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
		cls.digit = (ch >= 8'h30 && ch <= 8'h39);
		cls.ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.under = (ch == CH_UNDER);
		cls.colon = (ch == CH_COLON);
		cls.eq    = (ch == CH_EQ);
		cls.dot   = (ch == CH_DOT);
		cls.dash  = (ch == CH_DASH);
		cls.quote = (ch == CH_SQUOT) || (ch == CH_DQUOT);
	end

endmodule

`default_nettype wire

>>> design/tal_fsm.sv
// lexer state machine: holds lexer state, quote, name flag and sticky error,
// labels one character per advance and builds its token
// depends on tal_pkg, tal_class
`default_nettype none

module tal_fsm
	import tal_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       kind,
	input  wire logic [7:0] ch,
	input  wire logic       empty,
	output token_t          token
);

	lex_state_t state_q, state_d;
	logic [7:0] quote_q, quote_d;
	logic       name_seen_q, name_seen_d;
	logic [2:0] err_q, err_d;
	char_class_t cls;
	logic [1:0] role;
	logic       commit;
	logic [2:0] end_err;

	tal_class u_class (
		.ch  (ch),
		.cls (cls)
	);

	// state registers, updated once per consumed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LS_BEGIN;
			quote_q     <= '0;
			name_seen_q <= 1'b0;
			err_q       <= ERR_NONE;
		end else if (step) begin
			state_q     <= state_d;
			quote_q     <= quote_d;
			name_seen_q <= name_seen_d;
			err_q       <= err_d;
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		quote_d     = quote_q;
		name_seen_d = name_seen_q;
		err_d       = err_q;
		if (kind == KIND_END) begin
			state_d     = LS_BEGIN;
			quote_d     = '0;
			name_seen_d = 1'b0;
			err_d       = ERR_NONE;
		end else if (err_q == ERR_NONE) begin
			unique case (state_q)
				LS_BEGIN: begin
					if (cls.alpha) begin
						name_seen_d = 1'b1;
						state_d     = LS_TAG_NAME;
					end else begin
						err_d = ERR_TAG;
					end
				end
				LS_TAG_NAME: begin
					if (cls.alpha || cls.digit || cls.dot || cls.dash || cls.under) begin
						state_d = LS_TAG_NAME;
					end else if (cls.ws) begin
						state_d = LS_ATTR_GAP;
					end else begin
						err_d = ERR_TAG;
					end
				end
				LS_ATTR_GAP: begin
					if (cls.alpha || cls.under) begin
						state_d = LS_ATTR_NAME;
					end else if (!cls.ws) begin
						err_d = ERR_ATTR;
					end
				end
				LS_ATTR_NAME: begin
					if (cls.alpha || cls.digit || cls.dash || cls.colon || cls.dot
						|| cls.under) begin
						state_d = LS_ATTR_NAME;
					end else if (cls.eq) begin
						state_d = LS_AFTER_EQ;
					end else if (cls.ws) begin
						state_d = LS_AFTER_NAM;
					end else begin
						err_d = ERR_ATTR;
					end
				end
				LS_AFTER_NAM: begin
					// bare attribute: dropped along with the ending character
					if (cls.eq) begin
						state_d = LS_AFTER_EQ;
					end else if (!cls.ws) begin
						state_d = LS_ATTR_GAP;
					end
				end
				LS_AFTER_EQ: begin
					if (cls.quote) begin
						quote_d = ch;
						state_d = LS_QUOTED;
					end else if (!cls.ws) begin
						state_d = LS_UNQUOTED;
					end
				end
				LS_QUOTED: begin
					if (ch == quote_q) begin
						state_d = LS_ATTR_GAP;
					end
				end
				LS_UNQUOTED: begin
					if (cls.ws) begin
						state_d = LS_ATTR_GAP;
					end else if (cls.quote || cls.eq) begin
						err_d = ERR_VALUE;
					end
				end
				default: begin
					state_d = LS_BEGIN;
				end
			endcase
		end
	end

	// outputs: role and commit of the current character
	always_comb begin
		role   = ROLE_SKIP;
		commit = 1'b0;
		if (kind == KIND_CHAR && err_q == ERR_NONE) begin
			unique case (state_q)
				LS_BEGIN: begin
					if (cls.alpha) role = ROLE_TAG;
				end
				LS_TAG_NAME: begin
					if (cls.alpha || cls.digit || cls.dot || cls.dash || cls.under)
						role = ROLE_TAG;
				end
				LS_ATTR_GAP: begin
					if (cls.alpha || cls.under) role = ROLE_ANAME;
				end
				LS_ATTR_NAME: begin
					if (cls.alpha || cls.digit || cls.dash || cls.colon || cls.dot
						|| cls.under)
						role = ROLE_ANAME;
				end
				LS_AFTER_NAM: begin
					role = ROLE_SKIP;
				end
				LS_AFTER_EQ: begin
					if (!cls.quote && !cls.ws) role = ROLE_VALUE;
				end
				LS_QUOTED: begin
					if (ch == quote_q) commit = 1'b1;
					else role = ROLE_VALUE;
				end
				LS_UNQUOTED: begin
					if (cls.ws) commit = 1'b1;
					else if (!cls.quote && !cls.eq) role = ROLE_VALUE;
				end
				default: begin
					role = ROLE_SKIP;
				end
			endcase
		end
	end

	// final status of the tag on the end transaction
	assign end_err = (err_q != ERR_NONE) ? err_q
		: (name_seen_q ? ERR_NONE : ERR_UNNAMED);

	always_comb begin
		token.role          = role;
		token.byte_out      = (kind == KIND_END) ? 8'h00 : ch;
		token.attr_commit   = commit;
		token.error_code    = (kind == KIND_END) ? end_err : err_d;
		token.tag_done      = (kind == KIND_END);
		token.empty_tag_out = empty;
	end

endmodule

`default_nettype wire

>>> design/tag_attribute_lexer_core.sv
// top level of the tag attribute lexer: input register, lexer state machine,
// token output register
// depends on tal_pkg, tal_if, tal_fsm
`default_nettype none

// Lexes the interior of a start or empty tag one character per transaction and
// returns exactly one token per transaction: the character's role, the
// character itself, an attribute commit flag and the sticky error status; the
// end-of-tag transaction reports the final status and rearms the lexer. Each
// transaction passes an input register and then the lexer's combinational
// character-class decode into the token register, and one transaction is taken
// in every cycle while the token side keeps up. A token stalled on the output
// holds the lexer; the input register then takes at most one more character,
// and the input stalls until the token side accepts again.
module tag_attribute_lexer_core
	import tal_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	tal_char_if.sink  tag_chars,
	tal_token_if.source tokens
);

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       empty_s1;
	logic       valid_s2;
	token_t     token_s2;
	token_t     token;
	logic       ready_s2;
	logic       ready_s1;
	logic       step;

	// pipeline flow control
	assign ready_s2 = !valid_s2 || tokens.ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign step     = valid_s1 && ready_s2;
	assign tag_chars.ready = ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= tag_chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && tag_chars.valid) begin
			kind_s1  <= tag_chars.kind;
			byte_s1  <= tag_chars.byte_in;
			empty_s1 <= tag_chars.is_empty_tag;
		end
	end

	// lexer
	tal_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.kind   (kind_s1),
		.ch     (byte_s1),
		.empty  (empty_s1),
		.token  (token)
	);

	// token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			token_s2 <= token;
		end
	end

	// output channel
	assign tokens.valid         = valid_s2;
	assign tokens.role          = token_s2.role;
	assign tokens.byte_out      = token_s2.byte_out;
	assign tokens.attr_commit   = token_s2.attr_commit;
	assign tokens.error_code    = token_s2.error_code;
	assign tokens.tag_done      = token_s2.tag_done;
	assign tokens.empty_tag_out = token_s2.empty_tag_out;

endmodule

`default_nettype wire

>>> verif/tb_tag_attribute_lexer_core.sv
`timescale 1ns / 1ps
// self-checking testbench of tag_attribute_lexer_core: directed tags, then random
// well-formed, corrupted and noise tags, checked token by token against a predictor
// depends on tal_pkg, tal_if and the design files of tag_attribute_lexer_core

module tb_tag_attribute_lexer_core
	import tal_pkg::*;
();

	localparam int RANDOM_ITEMS  = 1150;
	localparam int DRAIN_EVERY   = 300;
	localparam int CALM_TAIL     = 150;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 10;

	// one pending input transaction, or a marker to wait for all tokens
	typedef struct {
		logic       kind;
		logic [7:0] ch;
		logic       empty;
		bit         drain;
	} char_item_t;

	logic clk;
	logic arst_n;

	tal_char_if  char_bus();
	tal_token_if token_bus();

	tag_attribute_lexer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_chars (char_bus),
		.tokens    (token_bus)
	);

	string ALPHA      = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
	string TAG_TAIL   = "ABCXYZabcxyz0123456789._-";
	string ANAME_HEAD = "ABMZamz_";
	string ANAME_TAIL = "ABMZamz0189-:._";

	char_item_t char_queue[$];
	token_t     pred_tokens[$];
	logic [7:0] tag_buf[$];

	// predictor state
	lex_state_t lx_state;
	logic [7:0] lx_quote;
	logic       lx_named;
	logic [2:0] lx_err;

	// bookkeeping
	char_item_t cur_item;
	bit drv_busy;
	bit calm;
	bit moved;
	int gap_left;
	int stall_left;
	int in_pct;
	int out_pct;
	int n_items;
	int n_tags;
	int n_accepted;
	int n_checked;
	int n_commits;
	int n_tag_errs;
	int n_unnamed;
	int n_drains;
	int n_fail;
	int idle_cycles;
	int cycle_cnt;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// character classes
	function automatic bit ch_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit ch_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit ch_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// next token of the lexer, advancing the predicted state
	function automatic token_t lex_predict(input logic kind, input logic [7:0] ch,
		input logic empty);
		token_t t;
		t = '0;
		t.empty_tag_out = empty;
		if (kind == KIND_END) begin
			t.tag_done = 1'b1;
			if (lx_err != ERR_NONE)
				t.error_code = lx_err;
			else
				t.error_code = lx_named ? ERR_NONE : ERR_UNNAMED;
			lx_state = LS_BEGIN;
			lx_quote = 8'h00;
			lx_named = 1'b0;
			lx_err   = ERR_NONE;
			return t;
		end
		t.byte_out = ch;
		if (lx_err == ERR_NONE) begin
			case (lx_state)
				LS_BEGIN: begin
					if (ch_alpha(ch)) begin
						t.role   = ROLE_TAG;
						lx_named = 1'b1;
						lx_state = LS_TAG_NAME;
					end else begin
						lx_err = ERR_TAG;
					end
				end
				LS_TAG_NAME: begin
					if (ch_alpha(ch) || ch_digit(ch) || ch == CH_DOT || ch == CH_DASH ||
						ch == CH_UNDER)
						t.role = ROLE_TAG;
					else if (ch_space(ch))
						lx_state = LS_ATTR_GAP;
					else
						lx_err = ERR_TAG;
				end
				LS_ATTR_GAP: begin
					if (ch_alpha(ch) || ch == CH_UNDER) begin
						t.role   = ROLE_ANAME;
						lx_state = LS_ATTR_NAME;
					end else if (!ch_space(ch)) begin
						lx_err = ERR_ATTR;
					end
				end
				LS_ATTR_NAME: begin
					if (ch_alpha(ch) || ch_digit(ch) || ch == CH_DASH || ch == CH_COLON ||
						ch == CH_DOT || ch == CH_UNDER)
						t.role = ROLE_ANAME;
					else if (ch == CH_EQ)
						lx_state = LS_AFTER_EQ;
					else if (ch_space(ch))
						lx_state = LS_AFTER_NAM;
					else
						lx_err = ERR_ATTR;
				end
				LS_AFTER_NAM: begin
					// a bare attribute is dropped along with the byte that ends it
					if (ch == CH_EQ)
						lx_state = LS_AFTER_EQ;
					else if (!ch_space(ch))
						lx_state = LS_ATTR_GAP;
				end
				LS_AFTER_EQ: begin
					if (ch == CH_SQUOT || ch == CH_DQUOT) begin
						lx_quote = ch;
						lx_state = LS_QUOTED;
					end else if (!ch_space(ch)) begin
						t.role   = ROLE_VALUE;
						lx_state = LS_UNQUOTED;
					end
				end
				LS_QUOTED: begin
					if (ch == lx_quote) begin
						t.attr_commit = 1'b1;
						lx_state      = LS_ATTR_GAP;
					end else begin
						t.role = ROLE_VALUE;
					end
				end
				default: begin
					if (ch_space(ch)) begin
						t.attr_commit = 1'b1;
						lx_state      = LS_ATTR_GAP;
					end else if (ch == CH_SQUOT || ch == CH_DQUOT || ch == CH_EQ) begin
						lx_err = ERR_VALUE;
					end else begin
						t.role = ROLE_VALUE;
					end
				end
			endcase
		end
		t.error_code = lx_err;
		return t;
	endfunction

	// stimulus helpers
	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_space();
		int v;
		v = $urandom_range(8, 13);
		return (v == 8) ? CH_SPACE : v[7:0];
	endfunction

	function automatic logic [7:0] unquoted_char();
		logic [7:0] c;
		do
			c = rand_byte();
		while (ch_space(c) || c == CH_SQUOT || c == CH_DQUOT || c == CH_EQ);
		return c;
	endfunction

	function automatic int idle_rate();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 6;
			default: return 30;
		endcase
	endfunction

	// append one byte to the tag being built
	task automatic add_byte(input logic [7:0] c);
		tag_buf = {tag_buf, c};
	endtask

	task automatic push_item(input logic kind, input logic [7:0] ch, input logic empty);
		char_item_t it;
		it.kind  = kind;
		it.ch    = ch;
		it.empty = empty;
		it.drain = 1'b0;
		char_queue = {char_queue, it};
		n_items++;
		if (kind == KIND_END)
			n_tags++;
	endtask

	task automatic push_drain();
		char_item_t it;
		it.kind  = KIND_CHAR;
		it.ch    = 8'h00;
		it.empty = 1'b0;
		it.drain = 1'b1;
		char_queue = {char_queue, it};
	endtask

	task automatic push_text(input string s, input logic empty);
		for (int i = 0; i < s.len(); i++)
			push_item(KIND_CHAR, s[i], empty);
	endtask

	// send tag_buf as one tag; the empty flag is mostly constant per tag
	task automatic push_tag_buf();
		logic empty;
		bit mixed;
		empty = 1'($urandom_range(0, 1));
		mixed = ($urandom_range(0, 7) == 0);
		foreach (tag_buf[i])
			push_item(KIND_CHAR, tag_buf[i], mixed ? logic'($urandom_range(0, 1)) : empty);
		push_item(KIND_END, rand_byte(), empty);
	endtask

	// tag name, then a few attributes: quoted, unquoted or bare
	task automatic build_good_tag();
		logic [7:0] q;
		tag_buf.delete();
		add_byte(pick(ALPHA));
		repeat ($urandom_range(0, 6)) add_byte(pick(TAG_TAIL));
		repeat ($urandom_range(0, 4)) begin
			repeat ($urandom_range(1, 3)) add_byte(rand_space());
			add_byte(pick(ANAME_HEAD));
			repeat ($urandom_range(0, 5)) add_byte(pick(ANAME_TAIL));
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 2)) add_byte(rand_space());
				end
				2, 3, 4, 5: begin
					q = $urandom_range(0, 1) ? CH_SQUOT : CH_DQUOT;
					repeat ($urandom_range(0, 1)) add_byte(rand_space());
					add_byte(CH_EQ);
					repeat ($urandom_range(0, 1)) add_byte(rand_space());
					add_byte(q);
					repeat ($urandom_range(0, 8)) begin
						logic [7:0] c;
						do
							c = rand_byte();
						while (c == q);
						add_byte(c);
					end
					add_byte(q);
				end
				default: begin
					repeat ($urandom_range(0, 1)) add_byte(rand_space());
					add_byte(CH_EQ);
					repeat ($urandom_range(0, 1)) add_byte(rand_space());
					repeat ($urandom_range(1, 6)) add_byte(unquoted_char());
				end
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			add_byte(rand_space());
	endtask

	// report one field mismatch
	task automatic check_field(input string fname, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: token %0d %s mismatch, expected %0d actual %0d",
				$time, n_checked, fname, exp_v, act_v);
			n_fail++;
		end
	endtask

	// stimulus, reset and end of run
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		char_bus.valid        = 1'b0;
		char_bus.kind         = KIND_CHAR;
		char_bus.byte_in      = 8'h00;
		char_bus.is_empty_tag = 1'b0;
		token_bus.ready       = 1'b0;
		lx_state = LS_BEGIN;
		lx_quote = 8'h00;
		lx_named = 1'b0;
		lx_err   = ERR_NONE;
		in_pct   = 6;
		out_pct  = 6;

		// directed: unnamed tag
		push_item(KIND_END, 8'h00, 1'b0);
		// double-quoted value holding a high byte, committed by its closing quote
		push_text("z a=\"", 1'b0);
		push_item(KIND_CHAR, 8'hFF, 1'b0);
		push_text("\"", 1'b0);
		push_item(KIND_END, 8'h00, 1'b0);
		// bare attribute, the byte after it dropped
		push_text("Q b c", 1'b1);
		push_item(KIND_END, 8'hFF, 1'b1);
		// unquoted value running into the end of the tag
		push_text("a k=v", 1'b0);
		push_item(KIND_END, 8'h00, 1'b1);
		// quote inside an unquoted value, then a byte after the error
		push_text("b v=w\"", 1'b1);
		push_item(KIND_CHAR, 8'h00, 1'b1);
		push_item(KIND_END, 8'h00, 1'b0);
		push_drain();

		// random tags: mostly well formed, some corrupted, some noise
		begin
			int target;
			int next_drain;
			target     = n_items + RANDOM_ITEMS;
			next_drain = n_items + DRAIN_EVERY;
			while (n_items < target) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						build_good_tag();
						if ($urandom_range(0, 1))
							tag_buf[$urandom_range(0, tag_buf.size() - 1)] = rand_byte();
						else
							tag_buf.insert($urandom_range(0, tag_buf.size()), rand_byte());
					end
					3, 4, 5: begin
						tag_buf.delete();
						if ($urandom_range(0, 1))
							add_byte(pick(ALPHA));
						repeat ($urandom_range(0, 12)) add_byte(rand_byte());
					end
					default: build_good_tag();
				endcase
				push_tag_buf();
				if (n_items >= next_drain) begin
					push_drain();
					next_drain += DRAIN_EVERY;
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (char_queue.size() == 0 && !drv_busy);
		wait (pred_tokens.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d transactions in %0d tags, %0d tokens checked, %0d attribute commits",
			n_accepted, n_tags, n_checked, n_commits);
		$display("%0d tags ended in error (%0d unnamed), %0d full drains of the token stream",
			n_tag_errs, n_unnamed, n_drains);
		if (n_fail == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// driver: next transaction at the falling edge, random gaps and drain pauses
	always @(negedge clk) begin
		if (!arst_n) begin
			char_bus.valid <= 1'b0;
		end else if (!drv_busy) begin
			if (gap_left > 0) begin
				gap_left--;
				char_bus.valid <= 1'b0;
			end else if (char_queue.size() != 0 && char_queue[0].drain) begin
				char_bus.valid <= 1'b0;
				if (pred_tokens.size() == 0) begin
					void'(char_queue.pop_front());
					n_drains++;
				end
			end else if (char_queue.size() != 0 && !calm && $urandom_range(0, 99) < in_pct) begin
				gap_left = $urandom_range(1, 16) - 1;
				char_bus.valid <= 1'b0;
			end else if (char_queue.size() != 0) begin
				cur_item = char_queue.pop_front();
				char_bus.kind         <= cur_item.kind;
				char_bus.byte_in      <= cur_item.ch;
				char_bus.is_empty_tag <= cur_item.empty;
				char_bus.valid        <= 1'b1;
				drv_busy = 1'b1;
			end else begin
				char_bus.valid <= 1'b0;
			end
		end
	end

	// token side back-pressure in random bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			token_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			token_bus.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < out_pct) begin
			stall_left = $urandom_range(1, 16) - 1;
			token_bus.ready <= 1'b0;
		end else begin
			token_bus.ready <= 1'b1;
		end
	end

	// monitor: predict on each accepted character, check each accepted token
	always @(posedge clk) begin
		token_t exp_tok;
		token_t new_tok;
		if (arst_n) begin
			moved = 1'b0;
			if (char_bus.valid && char_bus.ready) begin
				new_tok = lex_predict(char_bus.kind, char_bus.byte_in,
					char_bus.is_empty_tag);
				pred_tokens = {pred_tokens, new_tok};
				drv_busy = 1'b0;
				n_accepted++;
				moved = 1'b1;
			end
			if (token_bus.valid && token_bus.ready) begin
				moved = 1'b1;
				if (pred_tokens.size() == 0) begin
					$display("%0t: unexpected token, expected none actual byte %0d role %0d",
						$time, token_bus.byte_out, token_bus.role);
					n_fail++;
				end else begin
					exp_tok = pred_tokens.pop_front();
					check_field("role", int'(exp_tok.role), int'(token_bus.role));
					check_field("byte_out", int'(exp_tok.byte_out),
						int'(token_bus.byte_out));
					check_field("attr_commit", int'(exp_tok.attr_commit),
						int'(token_bus.attr_commit));
					check_field("error_code", int'(exp_tok.error_code),
						int'(token_bus.error_code));
					check_field("tag_done", int'(exp_tok.tag_done),
						int'(token_bus.tag_done));
					check_field("empty_tag_out", int'(exp_tok.empty_tag_out),
						int'(token_bus.empty_tag_out));
					if (exp_tok.attr_commit)
						n_commits++;
					if (exp_tok.tag_done && exp_tok.error_code != ERR_NONE)
						n_tag_errs++;
					if (exp_tok.tag_done && exp_tok.error_code == ERR_UNNAMED)
						n_unnamed++;
					n_checked++;
				end
			end

			// idle rates change now and then, and no new idle bursts start near the end
			cycle_cnt++;
			if (cycle_cnt % 128 == 0) begin
				in_pct  = idle_rate();
				out_pct = idle_rate();
			end
			calm = (n_accepted + CALM_TAIL >= n_items);

			// watchdog on cycles without any transaction
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d tokens outstanding",
					$time, idle_cycles, pred_tokens.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
